// ----- hw/rtl/bdlp_pkg.sv -----
// Shared types, constants and register codes for the button debounce and long-press unit.
// No dependencies; every other file in this folder refers to it by scoped names.
`default_nettype none

package bdlp_pkg;

   localparam int NUM_BUTTONS   = 2;
   localparam int BTN_ID_BITS   = 1;
   localparam int TIME_BITS_DEF = 32;
   localparam int NOW_BITS      = 32;
   localparam int DUR_BITS      = 32;
   localparam int DEB_BITS      = 16;
   localparam int LONG_BITS     = 16;
   localparam int MS_BITS       = 10;
   localparam int EV_BITS       = 2;
   localparam int SLOTS         = 2 * NUM_BUTTONS;
   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POLARITY   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEBOUNCE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_PRESS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MS_PER_TICK = 2'd3;

   localparam logic [NUM_BUTTONS-1:0] POLARITY_RST  = 2'd2;
   localparam logic [DEB_BITS-1:0]    DEBOUNCE_RST  = 16'd30;
   localparam logic [LONG_BITS-1:0]   LONG_RST      = 16'd800;
   localparam logic [MS_BITS-1:0]     MS_PER_TICK_RST = 10'd1;

   typedef enum logic [EV_BITS-1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_CLICK   = 2'd2,
      EV_LONG    = 2'd3
   } ev_code_type;

   typedef struct packed {
      logic [DEB_BITS-1:0]  debounce;
      logic [LONG_BITS-1:0] long_time;
   } lane_cfg_type;

   // Up to two events per button and tick: slot a comes first, slot b second.
   typedef struct packed {
      logic        a_valid;
      ev_code_type a_code;
      logic        b_valid;
      ev_code_type b_code;
   } lane_ev_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bdlp_req_if.sv -----
// Input channel: one poll tick with the raw pin levels and the tick count.
// Depends on bdlp_pkg for field widths.
`default_nettype none

interface bdlp_req_if;
   logic                                valid;
   logic                                ready;
   logic [bdlp_pkg::NUM_BUTTONS-1:0]    raw_levels;
   logic [bdlp_pkg::NOW_BITS-1:0]       now_ticks;

   modport source (output valid, output raw_levels, output now_ticks, input ready);
   modport sink   (input valid, input raw_levels, input now_ticks, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bdlp_rsp_if.sv -----
// Result channel: one button event per transaction.
// Depends on bdlp_pkg for field widths.
`default_nettype none

interface bdlp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bdlp_pkg::BTN_ID_BITS-1:0]  button_id;
   logic [bdlp_pkg::EV_BITS-1:0]      event_type;
   logic [bdlp_pkg::DUR_BITS-1:0]     elapsed_ms;
   logic                              last;

   modport source (output valid, output button_id, output event_type, output elapsed_ms,
                   output last, input ready);
   modport sink   (input valid, input button_id, input event_type, input elapsed_ms,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bdlp_lane.sv -----
// One button lane: debounce state, press timing and the events of one tick.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_lane #(
   parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  level,
   input  wire logic                  polarity,
   input  wire logic [TIME_BITS-1:0]  now,
   input  wire bdlp_pkg::lane_cfg_type cfg,
   output bdlp_pkg::lane_ev_type      ev,
   output logic      [TIME_BITS-1:0]  dur_a,
   output logic      [TIME_BITS-1:0]  dur_b
);

   logic                 raw_ff, raw_in;
   logic                 stable_ff, stable_in;
   logic                 long_sent_ff, long_sent_in;
   logic [TIME_BITS-1:0] changed_ff, changed_in;
   logic [TIME_BITS-1:0] start_ff, start_in;

   logic                 pressed;
   logic                 raw_chg;
   logic                 stab_chg;
   logic                 new_press;
   logic                 new_release;
   logic                 long_clear;
   logic                 fire_long;
   logic                 click;
   logic [TIME_BITS-1:0] raw_diff;
   logic [TIME_BITS-1:0] press_diff;
   logic [TIME_BITS-1:0] long_diff;

   always_comb begin
      pressed     = (level == polarity);
      raw_chg     = (pressed != raw_ff);
      // A fresh raw change is timestamped now, so its age is zero.
      raw_diff    = raw_chg ? '0 : (now - changed_ff);
      press_diff  = now - start_ff;
      stab_chg    = (pressed != stable_ff) && (raw_diff >= TIME_BITS'(cfg.debounce));
      new_press   = stab_chg && pressed;
      new_release = stab_chg && !pressed;
      stable_in   = stab_chg ? pressed : stable_ff;
      long_clear  = new_press ? 1'b0 : long_sent_ff;
      long_diff   = new_press ? '0 : press_diff;
      fire_long   = stable_in && !long_clear && (long_diff >= TIME_BITS'(cfg.long_time));
      click       = new_release && !long_sent_ff;

      raw_in       = pressed;
      changed_in   = raw_chg ? now : changed_ff;
      start_in     = new_press ? now : start_ff;
      long_sent_in = long_clear || fire_long;

      ev.a_valid = stab_chg || fire_long;
      ev.a_code  = new_press   ? bdlp_pkg::EV_PRESS :
                   new_release ? bdlp_pkg::EV_RELEASE : bdlp_pkg::EV_LONG;
      dur_a      = new_press ? '0 : press_diff;
      ev.b_valid = (new_press && fire_long) || click;
      ev.b_code  = click ? bdlp_pkg::EV_CLICK : bdlp_pkg::EV_LONG;
      dur_b      = click ? press_diff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff       <= 1'b0;
         stable_ff    <= 1'b0;
         long_sent_ff <= 1'b0;
         changed_ff   <= '0;
         start_ff     <= '0;
      end else if (accept) begin
         raw_ff       <= raw_in;
         stable_ff    <= stable_in;
         long_sent_ff <= long_sent_in;
         changed_ff   <= changed_in;
         start_ff     <= start_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bdlp_merge.sv -----
// Merging stage: holds one tick's events from all lanes and sends them in order, one per
// cycle unless rsp_ch stalls, scaling durations to ms. Depends on bdlp_pkg, bdlp_rsp_if.
`default_nettype none

module bdlp_merge #(
   parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire bdlp_pkg::lane_ev_type           ev    [bdlp_pkg::NUM_BUTTONS],
   input  wire logic [TIME_BITS-1:0]            dur_a [bdlp_pkg::NUM_BUTTONS],
   input  wire logic [TIME_BITS-1:0]            dur_b [bdlp_pkg::NUM_BUTTONS],
   input  wire logic [bdlp_pkg::MS_BITS-1:0]    ms_per_tick,
   output logic                                 take_ok,
   bdlp_rsp_if.source                           rsp_ch
);

   localparam int SLOTS     = bdlp_pkg::SLOTS;
   localparam int SLOT_BITS = bdlp_pkg::SLOT_BITS;
   localparam int PROD_BITS = bdlp_pkg::DUR_BITS + bdlp_pkg::MS_BITS;

   logic [SLOTS-1:0]                  pending_ff, pending_in;
   bdlp_pkg::ev_code_type             slot_code_ff [SLOTS];
   logic [TIME_BITS-1:0]              slot_dur_ff  [SLOTS];

   logic                              out_valid_ff, out_valid_in;
   logic [bdlp_pkg::BTN_ID_BITS-1:0]  out_id_ff;
   bdlp_pkg::ev_code_type             out_code_ff;
   logic [bdlp_pkg::DUR_BITS-1:0]     out_dur_ff;
   logic                              out_last_ff;

   logic [SLOT_BITS-1:0]              pick;
   logic [SLOTS-1:0]                  pick_oh;
   logic [SLOTS-1:0]                  rest;
   logic                              load_out;
   logic [SLOTS-1:0]                  new_pending;
   logic [PROD_BITS-1:0]              prod;
   logic [bdlp_pkg::DUR_BITS-1:0]     dur_ms;

   // Lowest pending slot goes first: button order, then slot a before slot b.
   always_comb begin
      pick = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (pending_ff[k]) begin
            pick = SLOT_BITS'(k);
         end
      end
      pick_oh  = SLOTS'(1) << pick;
      rest     = pending_ff & ~pick_oh;
      load_out = (|pending_ff) && (!out_valid_ff || rsp_ch.ready);
      take_ok  = load_out ? (rest == '0) : (pending_ff == '0);

      for (int i = 0; i < bdlp_pkg::NUM_BUTTONS; i++) begin
         new_pending[2*i]     = ev[i].a_valid;
         new_pending[2*i + 1] = ev[i].b_valid;
      end

      if (accept) begin
         pending_in = new_pending;
      end else if (load_out) begin
         pending_in = rest;
      end else begin
         pending_in = pending_ff;
      end

      prod   = PROD_BITS'(bdlp_pkg::DUR_BITS'(slot_dur_ff[pick])) * PROD_BITS'(ms_per_tick);
      dur_ms = (|prod[PROD_BITS-1:bdlp_pkg::DUR_BITS]) ? '1 : prod[bdlp_pkg::DUR_BITS-1:0];

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < bdlp_pkg::NUM_BUTTONS; i++) begin
            slot_code_ff[2*i]     <= ev[i].a_code;
            slot_dur_ff[2*i]      <= dur_a[i];
            slot_code_ff[2*i + 1] <= ev[i].b_code;
            slot_dur_ff[2*i + 1]  <= dur_b[i];
         end
      end
      if (load_out) begin
         out_id_ff   <= bdlp_pkg::BTN_ID_BITS'(pick >> 1);
         out_code_ff <= slot_code_ff[pick];
         out_dur_ff  <= dur_ms;
         out_last_ff <= (rest == '0);
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.button_id  = out_id_ff;
   assign rsp_ch.event_type = out_code_ff;
   assign rsp_ch.elapsed_ms = out_dur_ff;
   assign rsp_ch.last       = out_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/button_debounce_long_press_unit.sv -----
// Top level of the button debounce and long-press unit: configuration registers,
// one lane per button and the merging stage. Depends on bdlp_pkg, bdlp_req_if,
// bdlp_rsp_if, bdlp_lane and bdlp_merge.
//
//   channel  direction  contents
//   req_ch   in         raw_levels, now_ticks (one poll tick)
//   rsp_ch   out        button_id, event_type, elapsed_ms, last (one event)
//   csr_*    in         csr_wr_en, csr_index, csr_wdata (register writes)
//
// All lanes evaluate a tick in the cycle it is accepted; its events (zero to four)
// then leave the output register one per cycle while rsp_ch is not stalled, and the next
// tick is taken in the cycle its last event is loaded.
// Reset is synchronous and restores the register defaults and the released state.
// A stalled result channel holds the output register and, while events wait, req_ch.ready.
`default_nettype none

module button_debounce_long_press_unit #(
   parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   bdlp_req_if.sink                                  req_ch,
   bdlp_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_wr_en,
   input  wire logic [bdlp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [bdlp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int NB = bdlp_pkg::NUM_BUTTONS;

   logic [NB-1:0]                   polarity_ff;
   logic [bdlp_pkg::DEB_BITS-1:0]   debounce_ff;
   logic [bdlp_pkg::LONG_BITS-1:0]  long_ff;
   logic [bdlp_pkg::MS_BITS-1:0]    ms_per_tick_ff;

   logic                            accept;
   logic                            take_ok;
   bdlp_pkg::lane_cfg_type          lane_cfg;
   bdlp_pkg::lane_ev_type           lane_ev    [NB];
   logic [TIME_BITS-1:0]            lane_dur_a [NB];
   logic [TIME_BITS-1:0]            lane_dur_b [NB];

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff    <= bdlp_pkg::POLARITY_RST;
         debounce_ff    <= bdlp_pkg::DEBOUNCE_RST;
         long_ff        <= bdlp_pkg::LONG_RST;
         ms_per_tick_ff <= bdlp_pkg::MS_PER_TICK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bdlp_pkg::CSR_POLARITY: begin
               polarity_ff <= csr_wdata[NB-1:0];
            end
            bdlp_pkg::CSR_DEBOUNCE: begin
               debounce_ff <= csr_wdata[bdlp_pkg::DEB_BITS-1:0];
            end
            bdlp_pkg::CSR_LONG_PRESS: begin
               long_ff <= csr_wdata[bdlp_pkg::LONG_BITS-1:0];
            end
            bdlp_pkg::CSR_MS_PER_TICK: begin
               ms_per_tick_ff <= csr_wdata[bdlp_pkg::MS_BITS-1:0];
            end
         endcase
      end
   end

   assign accept             = req_ch.valid && take_ok;
   assign req_ch.ready       = take_ok;
   assign lane_cfg.debounce  = debounce_ff;
   assign lane_cfg.long_time = long_ff;

   for (genvar i = 0; i < NB; i++) begin : g_lane
      bdlp_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .level    (req_ch.raw_levels[i]),
         .polarity (polarity_ff[i]),
         .now      (req_ch.now_ticks[TIME_BITS-1:0]),
         .cfg      (lane_cfg),
         .ev       (lane_ev[i]),
         .dur_a    (lane_dur_a[i]),
         .dur_b    (lane_dur_b[i])
      );
   end

   bdlp_merge #(
      .TIME_BITS (TIME_BITS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ev          (lane_ev),
      .dur_a       (lane_dur_a),
      .dur_b       (lane_dur_b),
      .ms_per_tick (ms_per_tick_ff),
      .take_ok     (take_ok),
      .rsp_ch      (rsp_ch)
   );

`ifndef ASSERT_OFF
   // A press is reported the moment it becomes stable, so it carries no duration.
   a_press_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_type == bdlp_pkg::EV_PRESS) |-> rsp_ch.elapsed_ms == '0)
      else $error("press event with non-zero duration");

   // While a transaction that is not the last of its tick is stalled, no new tick may enter.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready && !rsp_ch.last) |-> !req_ch.ready)
      else $error("new tick accepted while events of the previous one wait");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire

// ----- dv/button_event_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the button debounce and long-press unit: it watches both channels and the
// register port, predicts every button event and compares it field by field.
// Depends on bdlp_pkg, bdlp_req_if and bdlp_rsp_if.

module button_event_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bdlp_req_if                                      req_ch,
   bdlp_rsp_if                                      rsp_ch,
   input  wire logic                                csr_wr_en,
   input  wire logic [bdlp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [bdlp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                       failures,
   output int                                       pending
);
   import bdlp_pkg::*;

   typedef struct {
      logic [BTN_ID_BITS-1:0] button;
      ev_code_type            kind;
      logic [DUR_BITS-1:0]    held_ms;
      logic                   last;
   } button_event_type;

   button_event_type awaited_events[$];

   logic [NUM_BUTTONS-1:0] polarity;
   logic [DEB_BITS-1:0]    deb_limit;
   logic [LONG_BITS-1:0]   long_limit;
   logic [MS_BITS-1:0]     ms_scale;

   logic [NUM_BUTTONS-1:0] seen_pressed;
   logic [NUM_BUTTONS-1:0] settled_pressed;
   logic [NUM_BUTTONS-1:0] long_done;
   logic [NOW_BITS-1:0]    level_since [NUM_BUTTONS];
   logic [NOW_BITS-1:0]    press_since [NUM_BUTTONS];

   task automatic note_mismatch(input string what);
      failures++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // The unit runs with a full 32-bit tick count, so plain 32-bit subtraction gives the
   // wrapped difference.
   function automatic logic [DUR_BITS-1:0] ticks_to_ms(input logic [NOW_BITS-1:0] ticks);
      logic [63:0] product;
      product = 64'(ticks) * 64'(ms_scale);
      return (product > 64'hFFFF_FFFF) ? '1 : product[DUR_BITS-1:0];
   endfunction

   function automatic void queue_event(input int b, input ev_code_type kind,
                                       input logic [DUR_BITS-1:0] held_ms);
      button_event_type ev;
      ev.button  = BTN_ID_BITS'(b);
      ev.kind    = kind;
      ev.held_ms = held_ms;
      ev.last    = 1'b0;
      awaited_events.push_back(ev);
   endfunction

   task automatic predict_tick(input logic [NUM_BUTTONS-1:0] levels,
                               input logic [NOW_BITS-1:0] now);
      logic                pressed;
      logic [NOW_BITS-1:0] held;
      int                  first;
      button_event_type    tail;
      first = awaited_events.size();
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         pressed = (levels[b] == polarity[b]);
         if (pressed != seen_pressed[b]) begin
            seen_pressed[b] = pressed;
            level_since[b]  = now;
         end
         held = now - level_since[b];
         if (pressed != settled_pressed[b] && held >= 32'(deb_limit)) begin
            settled_pressed[b] = pressed;
            if (pressed) begin
               press_since[b] = now;
               long_done[b]   = 1'b0;
               queue_event(b, EV_PRESS, '0);
            end else begin
               held = now - press_since[b];
               queue_event(b, EV_RELEASE, ticks_to_ms(held));
               if (!long_done[b]) queue_event(b, EV_CLICK, ticks_to_ms(held));
            end
         end
         held = now - press_since[b];
         if (settled_pressed[b] && !long_done[b] && held >= 32'(long_limit)) begin
            long_done[b] = 1'b1;
            queue_event(b, EV_LONG, ticks_to_ms(held));
         end
      end
      // The final event of a tick carries the last flag.
      if (awaited_events.size() > first) begin
         tail      = awaited_events.pop_back();
         tail.last = 1'b1;
         awaited_events.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      button_event_type want;
      if (reset) begin
         polarity        = POLARITY_RST;
         deb_limit       = DEBOUNCE_RST;
         long_limit      = LONG_RST;
         ms_scale        = MS_PER_TICK_RST;
         seen_pressed    = '0;
         settled_pressed = '0;
         long_done       = '0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            level_since[b] = '0;
            press_since[b] = '0;
         end
         awaited_events.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POLARITY:    polarity   = csr_wdata[NUM_BUTTONS-1:0];
               CSR_DEBOUNCE:    deb_limit  = csr_wdata[DEB_BITS-1:0];
               CSR_LONG_PRESS:  long_limit = csr_wdata[LONG_BITS-1:0];
               CSR_MS_PER_TICK: ms_scale   = csr_wdata[MS_BITS-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) predict_tick(req_ch.raw_levels, req_ch.now_ticks);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_events.size() == 0) begin
               note_mismatch($sformatf("unexpected event: button %0d type %0d duration %0d",
                                       rsp_ch.button_id, rsp_ch.event_type,
                                       rsp_ch.elapsed_ms));
            end else begin
               want = awaited_events.pop_front();
               if (rsp_ch.button_id !== want.button)
                  note_mismatch($sformatf("button_id %0d, expected %0d",
                                          rsp_ch.button_id, want.button));
               if (rsp_ch.event_type !== want.kind)
                  note_mismatch($sformatf("event_type %0d, expected %s",
                                          rsp_ch.event_type, want.kind.name()));
               if (rsp_ch.elapsed_ms !== want.held_ms)
                  note_mismatch($sformatf("elapsed_ms %0d, expected %0d",
                                          rsp_ch.elapsed_ms, want.held_ms));
               if (rsp_ch.last !== want.last)
                  note_mismatch($sformatf("last %0d, expected %0d", rsp_ch.last, want.last));
            end
         end
      end
      pending <= awaited_events.size();
   end

endmodule

// ----- dv/button_debounce_long_press_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the regression for the button debounce and long-press unit: clock, reset, poll tick
// stimulus, result back-pressure and the verdict. Depends on bdlp_pkg, both channel
// interfaces, the unit itself and button_event_checker.

module button_debounce_long_press_unit_tb;
   import bdlp_pkg::*;

   localparam int LIMIT_NS          = 2_000_000;
   localparam int LONG_STALL_CYCLES = 300;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int                       failures;
   int                       pending;

   logic                     calm;
   logic                     long_stall_due;
   logic [NUM_BUTTONS-1:0]   cur_pol;
   logic [NUM_BUTTONS-1:0]   intent;
   logic [DEB_BITS-1:0]      cur_deb;
   logic [LONG_BITS-1:0]     cur_long;
   logic [NOW_BITS-1:0]      tick_now;

   bdlp_req_if req_ch ();
   bdlp_rsp_if rsp_ch ();

   button_debounce_long_press_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   button_event_checker event_check (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #(LIMIT_NS);
      $display("button_debounce_long_press_unit regression: fail");
      $finish;
   end

   // Result side: short random stalls, quiet stretches, and one long hold-off on request.
   always begin
      @(posedge clock);
      if (long_stall_due) begin
         rsp_ch.ready   <= 1'b0;
         long_stall_due <= 1'b0;
         repeat (LONG_STALL_CYCLES) @(posedge clock);
         rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(10, 40)) @(posedge clock);
      end
   end

   task automatic send_tick(input logic [NUM_BUTTONS-1:0] levels,
                            input logic [NOW_BITS-1:0] now);
      req_ch.valid      <= 1'b1;
      req_ch.raw_levels <= levels;
      req_ch.now_ticks  <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Writes every register; a tick with no events may still be in flight, hence the pause.
   task automatic configure(input logic [CSR_DATA_BITS-1:0] pol, input logic [CSR_DATA_BITS-1:0] deb,
                            input logic [CSR_DATA_BITS-1:0] lng, input logic [CSR_DATA_BITS-1:0] ms);
      drain_results();
      repeat (6) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_POLARITY;
      csr_wdata <= pol;
      @(posedge clock);
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= lng;
      @(posedge clock);
      csr_index <= CSR_MS_PER_TICK;
      csr_wdata <= ms;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_pol  = pol[NUM_BUTTONS-1:0];
      cur_deb  = deb;
      cur_long = lng;
   endtask

   // A button that is meant to be pressed drives its active level, with occasional contact
   // bounce; time steps cluster around the debounce and long-press thresholds.
   task automatic random_tick();
      logic [NUM_BUTTONS-1:0] levels;
      int unsigned            step;
      for (int b = 0; b < NUM_BUTTONS; b++)
         if ($urandom_range(0, 5) == 0) intent[b] = !intent[b];
      levels = ~(intent ^ cur_pol);
      if ($urandom_range(0, 4) == 0) levels ^= NUM_BUTTONS'($urandom_range(1, 3));
      case ($urandom_range(0, 9))
         0:       step = 0;
         1:       step = 1;
         2, 3:    step = $urandom_range(0, 32'(cur_deb) + 1);
         4:       step = 32'(cur_deb);
         5, 6:    step = $urandom_range(0, 32'(cur_long) + 1);
         7:       step = 32'(cur_long);
         8:       step = $urandom_range(0, 2 * (32'(cur_deb) + 32'(cur_long)) + 2);
         default: step = $urandom();
      endcase
      tick_now += step;
      send_tick(levels, tick_now);
   endtask

   task automatic random_phase(input int count);
      for (int n = 0; n < count; n++) random_tick();
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.raw_levels <= '0;
      req_ch.now_ticks  <= '0;
      rsp_ch.ready      <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_POLARITY;
      csr_wdata         <= '0;
      long_stall_due    <= 1'b0;
      calm     = 1'b0;
      cur_pol  = POLARITY_RST;
      cur_deb  = DEBOUNCE_RST;
      cur_long = LONG_RST;
      intent   = '0;
      tick_now = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: press, long press, release without click, release with click,
      // then a bounce that never settles.
      send_tick(2'b11, 32'd0);
      send_tick(2'b11, 32'd29);
      send_tick(2'b11, 32'd30);
      send_tick(2'b11, 32'd830);
      send_tick(2'b00, 32'd1000);
      send_tick(2'b00, 32'd1030);
      send_tick(2'b01, 32'd1040);
      send_tick(2'b01, 32'd1070);
      send_tick(2'b10, 32'd1080);
      send_tick(2'b01, 32'd1090);
      send_tick(2'b01, 32'd1200);

      // No debounce and no long-press time, largest scale: four events in one tick,
      // durations across the tick wrap, and a saturated duration.
      configure(16'h0003, 16'h0000, 16'h0000, 16'h03FF);
      send_tick(2'b11, 32'hFFFF_FFF0);
      send_tick(2'b00, 32'h0000_0010);
      send_tick(2'b01, 32'h0000_0011);
      send_tick(2'b00, 32'hFFFF_FFFF);

      // Zero scale with stray high bits in the register writes.
      configure(16'hFFFC, 16'h0002, 16'h0005, 16'hFC00);
      send_tick(2'b00, 32'd0);
      send_tick(2'b00, 32'd2);
      send_tick(2'b00, 32'd7);
      send_tick(2'b11, 32'd8);
      send_tick(2'b11, 32'd10);

      // Longest debounce and long-press times.
      configure(16'hFFF2, 16'hFFFF, 16'hFFFF, 16'hFC01);
      send_tick(2'b00, 32'd100);
      send_tick(2'b00, 32'd65634);
      send_tick(2'b00, 32'd65635);
      send_tick(2'b00, 32'd131170);
      send_tick(2'b01, 32'd131171);
      send_tick(2'b01, 32'd196706);
      tick_now = 32'd196706;

      configure(16'd2, 16'd30, 16'd800, 16'd1);
      random_phase(45);

      configure(16'h0000, 16'h0000, 16'h0000, 16'hFC00);
      random_phase(45);

      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(40);

      configure(16'h0001, 16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)),
                16'($urandom_range(1, 1000)));
      random_phase(20);
      // The result side holds off while ticks keep coming, so the unit backs up.
      long_stall_due <= 1'b1;
      random_phase(20);
      drain_results();
      random_phase(10);

      configure(16'($urandom()), 16'($urandom_range(0, 300)), 16'($urandom_range(0, 3000)),
                16'($urandom()));
      random_phase(50);

      calm = 1'b1;
      configure(16'($urandom()), 16'($urandom_range(0, 60)), 16'($urandom_range(0, 600)),
                16'($urandom_range(0, 1023)));
      random_phase(40);

      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("button_debounce_long_press_unit regression: pass");
      end else begin
         $display("button_debounce_long_press_unit regression: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_req_if.sv
hw/rtl/bdlp_rsp_if.sv
hw/rtl/bdlp_lane.sv
hw/rtl/bdlp_merge.sv
hw/rtl/button_debounce_long_press_unit.sv
dv/button_event_checker.sv
dv/button_debounce_long_press_unit_tb.sv
